[design/assert_macros.svh]
// Assertion helpers for the design folder
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define ASSERT_RST(label, clk, prop) \
   label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst, prop)
`define ASSERT_RST(label, clk, prop)
`endif
`endif

[design/hmac_pkg.sv]
package hmac_pkg;
   localparam int KeyRegs = 4;
   localparam int CsrIdxWidth = 2;
   localparam logic [7:0] Ipad = 8'h36;
   localparam logic [7:0] Opad = 8'h5c;

   typedef enum logic [2:0] {
      ST_IDLE, ST_LOAD, ST_ROUND, ST_FOLD, ST_DONE
   } state_type;

   typedef struct packed {
      logic start;      // load h from init and the block in blk
      logic chain;      // load state from current h and the block in blk
   } sha_ctl_type;

   function automatic logic [31:0] round_const(input logic [5:0] i);
      logic [31:0] k [64];
      k = '{
         32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
         32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
         32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
         32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
         32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
         32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
         32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
         32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
         32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
         32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
         32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
      return k[i];
   endfunction

   localparam logic [255:0] HInit = {
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
endpackage

[design/hmac_sha256_tag64_sign_verify.sv]
// HMAC-SHA256 signer/verifier with a 64-bit truncated tag. The key comes from four
// csr registers. A request runs four SHA-256 compressions (inner key block, inner
// message block, outer key block, outer digest block) through one shared round unit
// at one round per cycle; each block passes through the LOAD, ROUND and FOLD states,
// and the next request is taken from the cycle after the response transaction
// completes.
`include "assert_macros.svh"
module hmac_sha256_tag64_sign_verify (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,   // cap_value[63:0], candidate_sig[127:64]
   input  logic         req_tuser,   // action
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [63:0]  rsp_tdata,   // signature[63:0]
   output logic         rsp_tuser,   // match
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [hmac_pkg::CsrIdxWidth-1:0] csr_index,
   input  logic [63:0]  csr_data
);
   logic [255:0] key_ff, key_in;
   hmac_pkg::state_type state_ff, state_in;
   logic [5:0] rnd_ff, rnd_in;
   logic [1:0] blk_ff, blk_in;
   logic act_ff, act_in;
   logic [63:0] cap_ff, cap_in, cand_ff, cand_in;
   logic [255:0] inner_ff, h;
   logic [511:0] blkd, kpad;
   hmac_pkg::sha_ctl_type ctl;
   logic run, fold;

   assign csr_ready = 1'b1;
   always_comb begin
      key_in = key_ff;
      if (csr_valid) begin
         key_in[(3 - csr_index)*64 +: 64] = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else begin
         key_ff <= key_in;
      end
   end

   always_comb begin
      kpad = {key_ff, 256'h0};
      for (int i = 0; i < 64; i++) begin
         kpad[i*8 +: 8] = kpad[i*8 +: 8] ^ ((blk_in == 2'd2) ? hmac_pkg::Opad : hmac_pkg::Ipad);
      end
      case (blk_in)
         2'd0, 2'd2: blkd = kpad;
         2'd1: blkd = {cap_ff, 32'h80000000, 352'h0, 64'd576};
         default: blkd = {inner_ff, 32'h80000000, 160'h0, 64'd768};
      endcase
   end

   always_comb begin
      state_in = state_ff;
      rnd_in = rnd_ff;
      blk_in = blk_ff;
      act_in = act_ff;
      cap_in = cap_ff;
      cand_in = cand_ff;
      ctl = '0;
      run = 1'b0;
      fold = 1'b0;
      req_tready = (state_ff == hmac_pkg::ST_IDLE);
      case (state_ff)
         hmac_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               act_in = req_tuser;
               cap_in = req_tdata[63:0];
               cand_in = req_tdata[127:64];
               blk_in = 2'd0;
               state_in = hmac_pkg::ST_LOAD;
            end
         end
         hmac_pkg::ST_LOAD: begin
            ctl.start = (blk_ff == 2'd0) || (blk_ff == 2'd2);
            ctl.chain = !ctl.start;
            rnd_in = '0;
            state_in = hmac_pkg::ST_ROUND;
         end
         hmac_pkg::ST_ROUND: begin
            run = 1'b1;
            rnd_in = rnd_ff + 6'd1;
            if (rnd_ff == 6'd63) begin
               state_in = hmac_pkg::ST_FOLD;
            end
         end
         hmac_pkg::ST_FOLD: begin
            fold = 1'b1;
            state_in = hmac_pkg::ST_LOAD;
            blk_in = blk_ff + 2'd1;
            if (blk_ff == 2'd3) begin
               state_in = hmac_pkg::ST_DONE;
            end
         end
         hmac_pkg::ST_DONE: begin
            if (rsp_tready) begin
               state_in = hmac_pkg::ST_IDLE;
            end
         end
         default: state_in = hmac_pkg::ST_IDLE;
      endcase
   end

   // inner digest is captured in the LOAD state that directly follows the second fold
   logic cap_inner;
   assign cap_inner = (state_ff == hmac_pkg::ST_LOAD) && (blk_ff == 2'd2);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hmac_pkg::ST_IDLE;
         rnd_ff <= '0;
         blk_ff <= '0;
      end else begin
         state_ff <= state_in;
         rnd_ff <= rnd_in;
         blk_ff <= blk_in;
      end
      act_ff <= act_in;
      cap_ff <= cap_in;
      cand_ff <= cand_in;
      if (cap_inner) begin
         inner_ff <= h;
      end
   end

   hmac_round u_round (
      .clock (clock),
      .ctl   (ctl),
      .run   (run),
      .fold  (fold),
      .rnd   (rnd_ff),
      .blk   (blkd),
      .h     (h)
   );

   // fold result lands in h at the end of FOLD; signature taken next cycle
   logic [63:0] final_sig;
   assign final_sig = h[255:192];
   assign rsp_tvalid = (state_ff == hmac_pkg::ST_DONE);
   assign rsp_tdata = final_sig;
   assign rsp_tuser = act_ff && (cand_ff != 64'h0) && (cand_ff == final_sig);

   `ASSERT_IMPL(a_busy_no_ready, clock, reset,
      (state_ff != hmac_pkg::ST_IDLE) |-> !req_tready)
   `ASSERT_IMPL(a_rsp_hold, clock, reset,
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
   `ASSERT_IMPL(a_start_idle, clock, reset,
      (req_tvalid && req_tready) |=> (state_ff == hmac_pkg::ST_LOAD))
   `ASSERT_IMPL(a_not_both, clock, reset, !(run && fold))
endmodule

[design/hmac_round.sv]
// One SHA-256 round per cycle while run is high, over a 16-word message window; h loaded on start, summed on fold
module hmac_round (
   input  logic                  clock,
   input  hmac_pkg::sha_ctl_type ctl,
   input  logic                  run,
   input  logic                  fold,
   input  logic [5:0]            rnd,
   input  logic [511:0]          blk,
   output logic [255:0]          h
);
   logic [255:0] h_ff, h_in, s_ff, s_in;
   logic [511:0] w_ff, w_in;
   logic [31:0] a, b, c, d, e, f, g, hh, wt, t1, t2, s0, s1, wn, w1, w14;

   always_comb begin
      {a, b, c, d, e, f, g, hh} = s_ff;
      wt  = w_ff[511:480];
      w1  = w_ff[479:448];
      w14 = w_ff[63:32];
      s0  = {w1[6:0], w1[31:7]} ^ {w1[17:0], w1[31:18]} ^ (w1 >> 3);
      s1  = {w14[16:0], w14[31:17]} ^ {w14[18:0], w14[31:19]} ^ (w14 >> 10);
      wn  = wt + s0 + w_ff[223:192] + s1;
      t1  = hh + ({e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]})
            + ((e & f) ^ (~e & g)) + hmac_pkg::round_const(rnd) + wt;
      t2  = ({a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]})
            + ((a & b) ^ (a & c) ^ (b & c));
      h_in = h_ff;
      s_in = s_ff;
      w_in = w_ff;
      if (ctl.start || ctl.chain) begin
         h_in = ctl.start ? hmac_pkg::HInit : h_ff;
         s_in = h_in;
         w_in = blk;
      end else if (run) begin
         s_in = {t1 + t2, a, b, c, d + t1, e, f, g};
         w_in = {w_ff[479:0], wn};
      end else if (fold) begin
         for (int i = 0; i < 8; i++) begin
            h_in[i*32 +: 32] = h_ff[i*32 +: 32] + s_ff[i*32 +: 32];
         end
      end
   end

   always_ff @(posedge clock) begin
      h_ff <= h_in;
      s_ff <= s_in;
      w_ff <= w_in;
   end

   assign h = h_ff;
endmodule

[dv/tb_top.sv]
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CYCLE_LIMIT = 12_000_000;
   localparam int unsigned N_RANDOM = 2000;
   localparam logic ACT_SIGN = 1'b0;
   localparam logic ACT_VERIFY = 1'b1;

   typedef struct {
      logic [63:0] signature;
      logic match;
   } tag_result_type;

   class tag_board;
      logic [63:0] key_word [hmac_pkg::KeyRegs];
      tag_result_type awaited [$];
      int unsigned errors;
      logic [31:0] kc [64];

      function new();
         kc = '{
            32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
            32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
            32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
            32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
            32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
            32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
            32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
            32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
            32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
            32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
            32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
            32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
            32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
         foreach (key_word[i]) key_word[i] = '0;
         errors = 0;
      endfunction

      function logic [31:0] ror(logic [31:0] x, int n);
         logic [63:0] d;
         d = {x, x} >> n;
         return d[31:0];
      endfunction

      // one compression; block holds message byte 0 in bits 511:504
      function logic [255:0] compress(logic [255:0] hv, logic [511:0] block);
         logic [31:0] w [64];
         logic [31:0] s [8];
         logic [31:0] t1, t2, s0, s1;
         for (int i = 0; i < 16; i++) w[i] = block[511 - 32*i -: 32];
         for (int i = 16; i < 64; i++) begin
            s0 = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
            s1 = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = w[i-16] + s0 + w[i-7] + s1;
         end
         for (int i = 0; i < 8; i++) s[i] = hv[255 - 32*i -: 32];
         for (int i = 0; i < 64; i++) begin
            t1 = s[7] + (ror(s[4], 6) ^ ror(s[4], 11) ^ ror(s[4], 25))
                 + ((s[4] & s[5]) ^ (~s[4] & s[6])) + kc[i] + w[i];
            t2 = (ror(s[0], 2) ^ ror(s[0], 13) ^ ror(s[0], 22))
                 + ((s[0] & s[1]) ^ (s[0] & s[2]) ^ (s[1] & s[2]));
            s[7] = s[6]; s[6] = s[5]; s[5] = s[4]; s[4] = s[3] + t1;
            s[3] = s[2]; s[2] = s[1]; s[1] = s[0]; s[0] = t1 + t2;
         end
         for (int i = 0; i < 8; i++) hv[255 - 32*i -: 32] += s[i];
         return hv;
      endfunction

      function logic [63:0] tag_for(logic [63:0] cap);
         logic [511:0] kblk, ipad_blk, opad_blk;
         logic [255:0] hv, inner;
         kblk = {key_word[0], key_word[1], key_word[2], key_word[3], 256'd0};
         ipad_blk = kblk ^ {64{8'h36}};
         opad_blk = kblk ^ {64{8'h5c}};
         // 72-byte inner message: second block is cap, pad byte, length 576 bits
         hv = compress(hmac_pkg::HInit, ipad_blk);
         inner = compress(hv, {cap, 8'h80, 376'd0, 64'd576});
         // 96-byte outer message: length 768 bits
         hv = compress(hmac_pkg::HInit, opad_blk);
         hv = compress(hv, {inner, 8'h80, 184'd0, 64'd768});
         return hv[255:192];
      endfunction

      function void note_request(logic act, logic [63:0] cap, logic [63:0] cand);
         tag_result_type r;
         r.signature = tag_for(cap);
         r.match = (act == ACT_VERIFY) && (cand != 0) && (cand == r.signature);
         awaited.push_back(r);
      endfunction

      function void check_response(logic [63:0] sig, logic match);
         tag_result_type r;
         if (awaited.size() == 0) begin
            $display("%0t: unexpected response sig=%h match=%b", $time, sig, match);
            errors++;
            return;
         end
         r = awaited.pop_front();
         if (sig !== r.signature) begin
            $display("%0t: signature expected %h actual %h", $time, r.signature, sig);
            errors++;
         end
         if (match !== r.match) begin
            $display("%0t: match expected %b actual %b", $time, r.match, match);
            errors++;
         end
      endfunction
   endclass

   logic clock, reset;
   logic req_tvalid, req_tready, req_tuser;
   logic [127:0] req_tdata;
   logic rsp_tvalid, rsp_tready, rsp_tuser;
   logic [63:0] rsp_tdata;
   logic csr_valid, csr_ready;
   logic [hmac_pkg::CsrIdxWidth-1:0] csr_index;
   logic [63:0] csr_data;

   tag_board board = new();
   int unsigned cycles = 0;
   int unsigned rsp_hold = 0;
   logic rsp_stall = 0;

   hmac_sha256_tag64_sign_verify DUT (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // receiver back-pressure: ready and stall phases alternate, mostly short, now and then a long one
   always @(posedge clock) begin
      if (rsp_hold > 0) begin
         rsp_hold <= rsp_hold - 1;
      end else if ($urandom_range(0, 3) == 0) begin
         rsp_stall <= ~rsp_stall;
         rsp_hold <= ($urandom_range(0, 19) == 0) ? $urandom_range(50, 400)
                                                  : $urandom_range(0, 4);
      end
      rsp_tready <= reset ? 1'b0 : ~rsp_stall;
   end

   always @(posedge clock)
      if (!reset && rsp_tvalid && rsp_tready) board.check_response(rsp_tdata, rsp_tuser);

   function automatic int unsigned pick_gap();
      if ($urandom_range(0, 2) == 0) return 0;
      return ($urandom_range(0, 29) == 0) ? $urandom_range(100, 600) : $urandom_range(1, 4);
   endfunction

   task automatic send_request(logic act, logic [63:0] cap, logic [63:0] cand);
      int unsigned gap;
      req_tvalid <= 1'b1;
      req_tuser <= act;
      req_tdata <= {cand, cap};
      do @(posedge clock); while (!req_tready);
      board.note_request(act, cap, cand);
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic write_key_word(logic [hmac_pkg::CsrIdxWidth-1:0] idx, logic [63:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      board.key_word[idx] = val;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (board.awaited.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   task automatic load_key(logic [63:0] k0, logic [63:0] k1, logic [63:0] k2,
                           logic [63:0] k3);
      drain();
      write_key_word(2'(0), k0);
      write_key_word(2'(1), k1);
      write_key_word(2'(2), k2);
      write_key_word(2'(3), k3);
   endtask

   // candidate mix for sign or verify: correct tag, zero, one flipped bit, random
   task automatic random_request();
      logic [63:0] cap, tag, cand;
      int unsigned pick;
      cap = rand64();
      if ($urandom_range(0, 15) == 0) cap = $urandom_range(0, 1) ? '0 : '1;
      tag = board.tag_for(cap);
      pick = $urandom_range(0, 9);
      if (pick < 4) cand = tag;
      else if (pick == 4) cand = '0;
      else if (pick < 7) cand = tag ^ (64'd1 << $urandom_range(0, 63));
      else cand = rand64();
      send_request($urandom_range(0, 1) ? ACT_VERIFY : ACT_SIGN, cap, cand);
   endtask

   initial begin
      logic [63:0] tag;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tuser = 1'b0;
      req_tdata = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // key still at its reset value
      send_request(ACT_SIGN, 64'd0, 64'd0);
      tag = board.tag_for(64'h0123456789abcdef);
      send_request(ACT_VERIFY, 64'h0123456789abcdef, tag);

      load_key('1, '1, '1, '1);
      tag = board.tag_for('1);
      send_request(ACT_SIGN, '1, tag);
      send_request(ACT_VERIFY, '1, tag);
      send_request(ACT_VERIFY, '1, 64'd0);
      send_request(ACT_VERIFY, '1, tag ^ 64'h8000_0000_0000_0000);
      send_request(ACT_VERIFY, '1, tag ^ 64'd1);
      tag = board.tag_for('0);
      send_request(ACT_VERIFY, '0, tag);
      send_request(ACT_VERIFY, '0, '1);

      load_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f,
               64'h1011121314151617, 64'h18191a1b1c1d1e1f);
      tag = board.tag_for(64'h8000_0000_0000_0001);
      send_request(ACT_VERIFY, 64'h8000_0000_0000_0001, tag);
      send_request(ACT_SIGN, 64'h8000_0000_0000_0001, 64'd0);
      send_request(ACT_VERIFY, 64'h7fff_ffff_ffff_fffe, '1);

      load_key('0, '0, '0, '0);
      tag = board.tag_for(64'h5555_aaaa_5555_aaaa);
      send_request(ACT_VERIFY, 64'h5555_aaaa_5555_aaaa, tag);
      send_request(ACT_SIGN, 64'haaaa_5555_aaaa_5555, 64'd0);

      for (int n = 0; n < N_RANDOM; n++) begin
         if (n % 400 == 0) load_key(rand64(), rand64(), rand64(), rand64());
         random_request();
      end

      req_tvalid <= 1'b0;
      while (board.awaited.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (board.errors == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end
endmodule

[files.f]
+incdir+design
design/hmac_pkg.sv
design/hmac_round.sv
design/hmac_sha256_tag64_sign_verify.sv
dv/tb_top.sv
